@@ rtl/asbrf_pkg.sv @@
// Shared types and constants for the advertising signature filter.
// No dependencies; imported by the parser, the tracker and the top level.
package asbrf_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MIN_SIGNAL    = 3'd0,
    REG_MATCH_AD_TYPE = 3'd1,
    REG_SIG_BYTE_ZERO = 3'd2,
    REG_SIG_BYTE_ONE  = 3'd3,
    REG_SIG_BYTE_FOUR = 3'd4
  } reg_idx_t;

  localparam logic        KIND_REPORT = 1'b0;
  localparam logic        KIND_SCAN   = 1'b1;

  localparam logic signed [7:0] MIN_SIGNAL_RST = -8'sd80;
  localparam logic [7:0]  AD_TYPE_RST   = 8'hFF;
  localparam logic [7:0]  SIG_ZERO_RST  = 8'hAA;
  localparam logic [7:0]  SIG_ONE_RST   = 8'h08;
  localparam logic [7:0]  SIG_FOUR_RST  = 8'hFA;
  localparam logic signed [7:0] SIGNAL_NONE = -8'sd128;

  // offsets within a structure: 0 length, 1 type, 2.. data
  localparam logic [7:0]  OFS_LEN   = 8'd0;
  localparam logic [7:0]  OFS_TYPE  = 8'd1;
  localparam logic [7:0]  OFS_DATA0 = 8'd2;
  localparam logic [7:0]  OFS_DATA1 = 8'd3;
  localparam logic [7:0]  OFS_DATA4 = 8'd6;
  localparam logic [7:0]  SIG_LEN_MIN = 8'd6;

  typedef struct packed {
    logic signed [7:0] min_signal;
    logic [7:0]        match_ad_type;
    logic [7:0]        sig_byte_zero;
    logic [7:0]        sig_byte_one;
    logic [7:0]        sig_byte_four;
  } cfg_t;

  typedef struct packed {
    logic              verdict_kind;
    logic              signature_found;
    logic              became_best;
    logic              found_device;
    logic signed [7:0] best_signal;
    logic [47:0]       best_address;
  } res_t;

endpackage

@@ rtl/asbrf_parse.sv @@
// Length-type-data structure walker for one advertising report.
// Depends on asbrf_pkg.
module asbrf_parse #(
  parameter int MAX_REPORT_BYTES = 62
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  asbrf_pkg::cmd_t   cmd,
  input  logic [7:0]        report_byte,
  input  logic              report_last,
  input  asbrf_pkg::cfg_t   cfg,
  output logic              found
);
  import asbrf_pkg::*;

  localparam int CW = $clog2(MAX_REPORT_BYTES + 1);

  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    struct_length, struct_length_next;
  logic [7:0]    struct_offset, struct_offset_next;
  logic [7:0]    struct_type_seen, struct_type_seen_next;
  logic [2:0]    signature_bits_ok, signature_bits_ok_next;
  logic          report_matched, report_matched_next;
  logic          report_halted, report_halted_next;

  always_comb begin
    byte_count_next        = byte_count;
    struct_length_next     = struct_length;
    struct_offset_next     = struct_offset;
    struct_type_seen_next  = struct_type_seen;
    signature_bits_ok_next = signature_bits_ok;
    report_matched_next    = report_matched;
    report_halted_next     = report_halted;
    if (!report_halted && byte_count < CW'(MAX_REPORT_BYTES)) begin
      byte_count_next = byte_count + CW'(1);
      if (struct_offset == OFS_LEN) begin
        if (report_byte == 8'd0) begin
          report_halted_next = 1'b1;
        end else begin
          struct_length_next     = report_byte;
          struct_type_seen_next  = 8'd0;
          signature_bits_ok_next = 3'b000;
          struct_offset_next     = OFS_TYPE;
        end
      end else begin
        if (struct_offset == OFS_TYPE) begin
          struct_type_seen_next = report_byte;
        end
        if (struct_offset == OFS_DATA0 && report_byte == cfg.sig_byte_zero) begin
          signature_bits_ok_next[0] = 1'b1;
        end
        if (struct_offset == OFS_DATA1 && report_byte == cfg.sig_byte_one) begin
          signature_bits_ok_next[1] = 1'b1;
        end
        if (struct_offset == OFS_DATA4 && report_byte == cfg.sig_byte_four) begin
          signature_bits_ok_next[2] = 1'b1;
        end
        if (struct_offset >= struct_length) begin
          if (struct_type_seen_next == cfg.match_ad_type &&
              struct_length >= SIG_LEN_MIN && signature_bits_ok_next == 3'b111) begin
            report_matched_next = 1'b1;
          end
          struct_offset_next = OFS_LEN;
        end else begin
          struct_offset_next = struct_offset + 8'd1;
        end
      end
    end
  end

  assign found = report_matched_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      struct_length     <= '0;
      struct_offset     <= OFS_LEN;
      struct_type_seen  <= '0;
      signature_bits_ok <= '0;
      report_matched    <= 1'b0;
      report_halted     <= 1'b0;
    end else if (step) begin
      case (cmd)
        CMD_START, CMD_END: begin
          byte_count        <= '0;
          struct_length     <= '0;
          struct_offset     <= OFS_LEN;
          struct_type_seen  <= '0;
          signature_bits_ok <= '0;
          report_matched    <= 1'b0;
          report_halted     <= 1'b0;
        end
        CMD_BYTE: begin
          if (report_last) begin
            byte_count        <= '0;
            struct_length     <= '0;
            struct_offset     <= OFS_LEN;
            struct_type_seen  <= '0;
            signature_bits_ok <= '0;
            report_matched    <= 1'b0;
            report_halted     <= 1'b0;
          end else begin
            byte_count        <= byte_count_next;
            struct_length     <= struct_length_next;
            struct_offset     <= struct_offset_next;
            struct_type_seen  <= struct_type_seen_next;
            signature_bits_ok <= signature_bits_ok_next;
            report_matched    <= report_matched_next;
            report_halted     <= report_halted_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/asbrf_best.sv @@
// Best-device tracker and verdict builder.
// Depends on asbrf_pkg.
module asbrf_best (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  asbrf_pkg::cmd_t   cmd,
  input  logic              report_last,
  input  logic signed [7:0] signal_strength,
  input  logic [47:0]       device_address,
  input  asbrf_pkg::cfg_t   cfg,
  input  logic              found,
  output logic              has_result,
  output asbrf_pkg::res_t   res
);
  import asbrf_pkg::*;

  logic signed [7:0] best_rssi_reg, best_rssi_next;
  logic [47:0]       best_addr_reg, best_addr_next;
  logic              report_end;
  logic              upd;

  always_comb begin
    report_end = (cmd == CMD_BYTE) && report_last;
    upd = report_end && found && (signal_strength > best_rssi_reg) &&
          (signal_strength >= cfg.min_signal);
    best_rssi_next = upd ? signal_strength : best_rssi_reg;
    best_addr_next = upd ? device_address : best_addr_reg;
    has_result = report_end || (cmd == CMD_END);
    res.verdict_kind    = (cmd == CMD_END) ? KIND_SCAN : KIND_REPORT;
    res.signature_found = report_end && found;
    res.became_best     = upd;
    res.found_device    = (best_rssi_next != SIGNAL_NONE);
    res.best_signal     = best_rssi_next;
    res.best_address    = best_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_rssi_reg <= SIGNAL_NONE;
      best_addr_reg <= '0;
    end else if (step) begin
      if (cmd == CMD_START) begin
        best_rssi_reg <= SIGNAL_NONE;
        best_addr_reg <= '0;
      end else begin
        best_rssi_reg <= best_rssi_next;
        best_addr_reg <= best_addr_next;
      end
    end
  end

endmodule

@@ rtl/adv_signature_best_rssi_filter_top.sv @@
// Top level of the advertising signature filter: input register, parser,
// best-device tracker, result register and APB register file.
// Depends on asbrf_pkg, asbrf_parse and asbrf_best.
//
// Usage:
//   Slave stream carries one command per transfer: start of scan (clears the
//   best device), a report byte, or end of scan. tlast marks the last byte of
//   a report; signal strength and address are taken from that byte.
//   Master stream carries one verdict per report end and per end of scan.
//   A verdict passes the input register and the result register before it
//   appears on the master side. Throughput: one transfer per cycle while no
//   transfer with a verdict waits; the parse state is a single byte step
//   held in registers. When the master side stalls, one more transfer is
//   held in the input register; transfers without a verdict keep flowing
//   until one with a verdict waits. Reset clears the parse, the best device
//   and the registers to defaults. The user must write registers over APB
//   only while the stream is idle; the block does not enforce it.
module adv_signature_best_rssi_filter_top #(
  parameter int MAX_REPORT_BYTES = 62
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // report_byte, signal_strength, device_address
  input  logic [1:0]  s_tuser,   // command
  input  logic        s_tlast,   // report_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // signature_found, became_best, found_device,
                                 // best_signal, best_address, zero fill
  output logic        m_tuser,   // verdict_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import asbrf_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic [1:0]  in_user;
  logic [63:0] in_data;
  logic        in_last;
  cmd_t        in_cmd;
  logic        advance;
  logic        step;
  logic        found;
  logic        has_result;
  res_t        res;
  res_t        out_res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_signal    <= MIN_SIGNAL_RST;
      cfg.match_ad_type <= AD_TYPE_RST;
      cfg.sig_byte_zero <= SIG_ZERO_RST;
      cfg.sig_byte_one  <= SIG_ONE_RST;
      cfg.sig_byte_four <= SIG_FOUR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_MIN_SIGNAL:    cfg.min_signal    <= pwdata[7:0];
        REG_MATCH_AD_TYPE: cfg.match_ad_type <= pwdata[7:0];
        REG_SIG_BYTE_ZERO: cfg.sig_byte_zero <= pwdata[7:0];
        REG_SIG_BYTE_ONE:  cfg.sig_byte_one  <= pwdata[7:0];
        REG_SIG_BYTE_FOUR: cfg.sig_byte_four <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MIN_SIGNAL:    prdata = {{24{cfg.min_signal[7]}}, cfg.min_signal};
      REG_MATCH_AD_TYPE: prdata = {24'd0, cfg.match_ad_type};
      REG_SIG_BYTE_ZERO: prdata = {24'd0, cfg.sig_byte_zero};
      REG_SIG_BYTE_ONE:  prdata = {24'd0, cfg.sig_byte_one};
      REG_SIG_BYTE_FOUR: prdata = {24'd0, cfg.sig_byte_four};
      default:           prdata = 32'd0;
    endcase
  end

  assign in_cmd   = cmd_t'(in_user);
  // hold a transfer only when it needs the result register and that is full
  assign advance  = in_valid && (!has_result || !m_tvalid || m_tready);
  assign step     = advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_user <= s_tuser;
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  asbrf_parse #(
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cmd         (in_cmd),
    .report_byte (in_data[7:0]),
    .report_last (in_last),
    .cfg         (cfg),
    .found       (found)
  );

  asbrf_best u_best (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .cmd             (in_cmd),
    .report_last     (in_last),
    .signal_strength (in_data[15:8]),
    .device_address  (in_data[63:16]),
    .cfg             (cfg),
    .found           (found),
    .has_result      (has_result),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.verdict_kind;
  assign m_tdata = {5'd0, out_res.best_address, out_res.best_signal,
                    out_res.found_device, out_res.became_best, out_res.signature_found};

endmodule

@@ rtl/asbrf_check.sv @@
// Port-level checker for the advertising signature filter top level,
// bound to adv_signature_best_rssi_filter_top. Depends on nothing else.
module asbrf_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("master transfer dropped while stalled");

  a_scan_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0] && !m_tdata[1])
    else $error("end-of-scan verdict carries report flags");

  a_best_needs_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("best device chosen without signature");

  a_found_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2] == (m_tdata[10:3] != 8'h80))
    else $error("found_device disagrees with best_signal");

  a_best_has_signal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[2])
    else $error("new best device not reported as found");

endmodule

bind adv_signature_best_rssi_filter_top asbrf_check u_asbrf_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
